@@ rtl/gwm_pkg.sv @@
// ----------------------------------------------------------------------------
// gwm_pkg
// Shared constants, register codes and helpers for the glob wildcard matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package gwm_pkg;

    localparam int REG_BYTES  = 32;
    localparam int WORD_COUNT = 4;
    localparam int LEN_W      = 6;
    localparam int BYTE_W     = 8;
    localparam int DATA_W     = 64;
    localparam int IDX_W      = 3;

    localparam logic [BYTE_W-1:0] CH_STAR  = 8'h2A;
    localparam logic [BYTE_W-1:0] CH_QMARK = 8'h3F;
    localparam logic [BYTE_W-1:0] CH_UP_A  = 8'h41;
    localparam logic [BYTE_W-1:0] CH_UP_Z  = 8'h5A;
    localparam logic [BYTE_W-1:0] CASE_OFS = 8'd32;

    typedef enum logic [IDX_W-1:0] {
        CFG_WORD0 = 3'd0,
        CFG_WORD1 = 3'd1,
        CFG_WORD2 = 3'd2,
        CFG_WORD3 = 3'd3,
        CFG_LEN   = 3'd4,
        CFG_FOLD  = 3'd5
    } t_cfg_idx;

    function automatic logic [BYTE_W-1:0] fold_char(input logic [BYTE_W-1:0] c,
                                                    input logic en);
        logic [BYTE_W-1:0] r;
        r = c;
        if (en && (c >= CH_UP_A) && (c <= CH_UP_Z)) begin
            r = c + CASE_OFS;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/glob_wildcard_matcher_top.sv @@
// Flow: an accepted character waits in the item queue until the NFA consumes it;
//   a final one also waits for room in the result queue, where its match flag goes.
// Throughput: one character per cycle, unless a final character waits for room.
// Reset (synchronous, active low): pattern registers cleared, both queues
//   emptied, active set back to the start position.
// ----------------------------------------------------------------------------
// glob_wildcard_matcher_top
// Glob matcher: config registers, classify front, item queue, NFA back end,
// result queue.
// ----------------------------------------------------------------------------
`default_nettype none

module glob_wildcard_matcher_top #(
    parameter int MAX_PATTERN_LEN = 32
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        push,
    output logic                             full,
    input  wire logic [gwm_pkg::BYTE_W-1:0]  i_name_char,
    input  wire logic                        i_last_char,
    input  wire logic                        pop,
    output logic                             empty,
    output logic                             o_matched,
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [gwm_pkg::IDX_W-1:0]   i_cfg_index,
    input  wire logic [gwm_pkg::DATA_W-1:0]  i_cfg_data
);
    import gwm_pkg::*;

    localparam int LEN_CAP = (MAX_PATTERN_LEN < REG_BYTES) ? MAX_PATTERN_LEN : REG_BYTES;
    localparam int NP      = LEN_CAP + 1;

    logic [WORD_COUNT-1:0][DATA_W-1:0] r_pat_word;
    logic [LEN_W-1:0]                  r_pat_len;
    logic                              r_case_fold;

    logic [REG_BYTES-1:0][BYTE_W-1:0]  pat_bytes;
    logic [LEN_W-1:0]                  len_eff;
    logic [LEN_CAP-1:0]                star, in_len, hit;
    logic [NP-1:0]                     at_len;

    logic [LEN_CAP:0]                  q_wdata, q_rdata;
    logic                              q_empty, q_pop;
    logic                              res_push, res_matched, res_full;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_word  <= '0;
            r_pat_len   <= '0;
            r_case_fold <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_WORD0: r_pat_word[0] <= i_cfg_data;
                CFG_WORD1: r_pat_word[1] <= i_cfg_data;
                CFG_WORD2: r_pat_word[2] <= i_cfg_data;
                CFG_WORD3: r_pat_word[3] <= i_cfg_data;
                CFG_LEN:   r_pat_len     <= i_cfg_data[LEN_W-1:0];
                CFG_FOLD:  r_case_fold   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign pat_bytes = r_pat_word;
    assign len_eff   = (r_pat_len > LEN_W'(LEN_CAP)) ? LEN_W'(LEN_CAP) : r_pat_len;

    always_comb begin
        for (int i = 0; i < LEN_CAP; i++) begin
            in_len[i] = (LEN_W'(i) < len_eff);
            star[i]   = in_len[i] && (pat_bytes[i] == CH_STAR);
        end
        for (int k = 0; k < NP; k++) begin
            at_len[k] = (len_eff == LEN_W'(k));
        end
    end

    gwm_front #(
        .LEN_CAP     (LEN_CAP)
    ) u_front (
        .i_pat_bytes (pat_bytes[LEN_CAP-1:0]),
        .i_case_fold (r_case_fold),
        .i_name_char (i_name_char),
        .o_hit       (hit)
    );

    assign q_wdata = {hit, i_last_char};

    gwm_queue #(
        .W       (LEN_CAP + 1),
        .DEPTH   (2)
    ) u_item_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (q_wdata),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_empty (q_empty)
    );

    gwm_back #(
        .LEN_CAP       (LEN_CAP)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item_valid  (!q_empty),
        .i_hit         (q_rdata[LEN_CAP:1]),
        .i_last        (q_rdata[0]),
        .o_item_pop    (q_pop),
        .i_star        (star),
        .i_in_len      (in_len),
        .i_at_len      (at_len),
        .o_res_push    (res_push),
        .o_res_matched (res_matched),
        .i_res_full    (res_full)
    );

    gwm_queue #(
        .W       (1),
        .DEPTH   (2)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_matched),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (o_matched),
        .o_empty (empty)
    );

endmodule

`default_nettype wire

@@ rtl/gwm_front.sv @@
// ----------------------------------------------------------------------------
// gwm_front
// Classifies one name character against every pattern byte: hit vector.
// ----------------------------------------------------------------------------
`default_nettype none

module gwm_front #(
    parameter int LEN_CAP = 32
) (
    input  wire logic [LEN_CAP-1:0][gwm_pkg::BYTE_W-1:0] i_pat_bytes,
    input  wire logic                                    i_case_fold,
    input  wire logic [gwm_pkg::BYTE_W-1:0]              i_name_char,
    output logic      [LEN_CAP-1:0]                      o_hit
);
    import gwm_pkg::*;

    logic [BYTE_W-1:0] c_fold;

    assign c_fold = fold_char(i_name_char, i_case_fold);

    always_comb begin
        for (int i = 0; i < LEN_CAP; i++) begin
            o_hit[i] = (i_pat_bytes[i] == CH_QMARK) ||
                       (fold_char(i_pat_bytes[i], i_case_fold) == c_fold);
        end
    end

endmodule

`default_nettype wire

@@ rtl/gwm_queue.sv @@
// ----------------------------------------------------------------------------
// gwm_queue
// Small synchronous FIFO; push ignored when full, pop ignored when empty.
// ----------------------------------------------------------------------------
`default_nettype none

module gwm_queue #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_data,
    output logic              o_full,
    input  wire logic         i_pop,
    output logic [W-1:0]      o_data,
    output logic              o_empty
);
    import gwm_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          wr_en, rd_en;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (wr_en) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (rd_en) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (wr_en && !rd_en) begin
            n_cnt = r_cnt + 1'b1;
        end else if (rd_en && !wr_en) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

@@ rtl/gwm_back.sv @@
// ----------------------------------------------------------------------------
// gwm_back
// Bit-parallel NFA over pattern positions; star closure via prefix network.
// ----------------------------------------------------------------------------
`default_nettype none

module gwm_back #(
    parameter int LEN_CAP = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_item_valid,
    input  wire logic [LEN_CAP-1:0] i_hit,
    input  wire logic               i_last,
    output logic                    o_item_pop,
    input  wire logic [LEN_CAP-1:0] i_star,
    input  wire logic [LEN_CAP-1:0] i_in_len,
    input  wire logic [LEN_CAP:0]   i_at_len,
    output logic                    o_res_push,
    output logic                    o_res_matched,
    input  wire logic               i_res_full
);
    import gwm_pkg::*;

    localparam int NP = LEN_CAP + 1;

    logic [NP-1:0]      r_active, n_active;
    logic [NP-1:0]      live, cur, nxt, fin;
    logic [LEN_CAP-1:0] fwd;
    logic               deq;

    function automatic logic [NP-1:0] expand(input logic [NP-1:0] set,
                                             input logic [LEN_CAP-1:0] star);
        logic [NP-1:0] e;
        logic [NP-1:0] p;
        int            s;
        e = set;
        p = {star, 1'b0};
        for (s = 1; s < NP; s = s * 2) begin
            e = e | ((e << s) & p);
            p = p & (p << s);
        end
        return e;
    endfunction

    assign live = {1'b0, i_in_len} | i_at_len;
    assign cur  = expand(r_active & live, i_star);
    assign fwd  = cur[LEN_CAP-1:0] & i_in_len;
    assign nxt  = {1'b0, fwd & i_star} | {fwd & ~i_star & i_hit, 1'b0};
    assign fin  = expand(nxt, i_star);

    assign deq           = i_item_valid && (!i_last || !i_res_full);
    assign o_item_pop    = deq;
    assign o_res_push    = deq && i_last;
    assign o_res_matched = |(fin & i_at_len);

    always_comb begin
        n_active = r_active;
        if (deq) begin
            n_active = i_last ? NP'(1) : nxt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= NP'(1);
        end else begin
            r_active <= n_active;
        end
    end

    a_restart_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (deq && i_last) |=> (r_active == NP'(1)))
        else $error("active set not restarted after final character");

    a_result_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push |-> !i_res_full)
        else $error("result pushed into full queue");

    a_hold_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_item_valid |=> (r_active == $past(r_active)))
        else $error("active set changed without an item");

endmodule

`default_nettype wire

@@ test/tb_glob_wildcard_matcher_top.sv @@
// ----------------------------------------------------------------------------
// tb_glob_wildcard_matcher_top
// Self-checking bench: streams file-name characters through the matcher and
// compares each end-of-name match flag with a glob NFA model kept in the bench.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_glob_wildcard_matcher_top;

    timeunit 1ns;
    timeprecision 1ps;

    import gwm_pkg::*;

    localparam int PAT_MAX         = 32;
    localparam int RANDOM_CHARS    = 1200;
    localparam int DRAIN_CYCLES    = 64;
    localparam int LONG_HOLD       = 400;
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int DIRECTED_NAMES  = 6;

    typedef struct packed {
        logic [BYTE_W-1:0] ch;
        logic              last;
    } t_name_beat;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              push = 1'b0;
    logic              full;
    logic [BYTE_W-1:0] name_char = '0;
    logic              last_char = 1'b0;
    logic              pop = 1'b0;
    logic              empty;
    logic              matched;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [IDX_W-1:0]  cfg_index = '0;
    logic [DATA_W-1:0] cfg_data = '0;

    // pattern mirror and live NFA positions
    logic [DATA_W-1:0] pat_words [WORD_COUNT] = '{default: '0};
    logic [LEN_W-1:0]  pat_len_reg = '0;
    logic              fold_en = 1'b0;
    logic [PAT_MAX:0]  live_set = (PAT_MAX + 1)'(1);

    t_name_beat pending_chars [$];
    logic       match_expected_q [$];

    logic in_beat = 1'b0;
    logic out_beat = 1'b0;
    int   send_gap = 0;
    int   send_burst = 0;
    int   recv_gap = 0;
    int   recv_burst = 0;
    logic hold_done = 1'b0;
    int   idle_cycles = 0;
    int   error_count = 0;
    int   chars_seen = 0;
    int   results_seen = 0;
    int   matches_seen = 0;
    int   cfg_writes = 0;
    int   queued_chars = 0;
    int   settings_used = 0;

    glob_wildcard_matcher_top #(
        .MAX_PATTERN_LEN(PAT_MAX)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .push        (push),
        .full        (full),
        .i_name_char (name_char),
        .i_last_char (last_char),
        .pop         (pop),
        .empty       (empty),
        .o_matched   (matched),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic int active_len();
        int n;
        n = pat_len_reg;
        if (n > PAT_MAX) n = PAT_MAX;
        if (n > REG_BYTES) n = REG_BYTES;
        return n;
    endfunction

    function automatic logic [BYTE_W-1:0] pattern_byte(input int i);
        return pat_words[i / 8][(i % 8) * 8 +: 8];
    endfunction

    function automatic logic [BYTE_W-1:0] lower_ascii(input logic [BYTE_W-1:0] c);
        if (fold_en && c >= CH_UP_A && c <= CH_UP_Z) return c + CASE_OFS;
        return c;
    endfunction

    // a live position sitting on a star also enables the position after it
    function automatic logic [PAT_MAX:0] star_closure(input logic [PAT_MAX:0] s,
                                                      input int n);
        for (int i = 0; i <= PAT_MAX; i++) begin
            if (i > n) s[i] = 1'b0;
        end
        for (int i = 0; i < n; i++) begin
            if (s[i] && pattern_byte(i) == CH_STAR) s[i + 1] = 1'b1;
        end
        return s;
    endfunction

    function automatic void consume_char(input logic [BYTE_W-1:0] ch, input logic last);
        int                n;
        logic [BYTE_W-1:0] c;
        logic [BYTE_W-1:0] p;
        logic [PAT_MAX:0]  cur;
        logic [PAT_MAX:0]  nxt;
        n   = active_len();
        c   = lower_ascii(ch);
        cur = star_closure(live_set, n);
        nxt = '0;
        for (int i = 0; i < n; i++) begin
            if (cur[i]) begin
                p = pattern_byte(i);
                if (p == CH_STAR) nxt[i] = 1'b1;
                else if (p == CH_QMARK || lower_ascii(p) == c) nxt[i + 1] = 1'b1;
            end
        end
        if (!last) begin
            live_set = nxt;
        end else begin
            nxt = star_closure(nxt, n);
            match_expected_q.push_back(nxt[n]);
            live_set = (PAT_MAX + 1)'(1);
        end
    endfunction

    function automatic logic [BYTE_W-1:0] pick_name_char();
        case ($urandom_range(0, 11))
            0, 1:    return "a";
            2:       return "b";
            3:       return "c";
            4:       return "A";
            5:       return "B";
            6:       return "C";
            7:       return ".";
            8:       return 8'h00;
            9:       return 8'hFF;
            10:      return CH_STAR;
            default: return BYTE_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 15);
        return $urandom_range(20, 60);
    endfunction

    function automatic void queue_char(input logic [BYTE_W-1:0] ch, input logic last);
        pending_chars.push_back('{ch: ch, last: last});
        queued_chars++;
    endfunction

    // well-formed names follow the pattern, some with one edit; the rest is noise
    function automatic void add_name(input logic well_formed, input logic complete);
        logic [BYTE_W-1:0] nm [$];
        logic [BYTE_W-1:0] p;
        int                n;
        n = active_len();
        if (well_formed) begin
            for (int k = 0; k < n; k++) begin
                p = pattern_byte(k);
                if (p == CH_STAR) begin
                    repeat ($urandom_range(0, 3)) nm.push_back(pick_name_char());
                end else if (p == CH_QMARK) begin
                    nm.push_back(pick_name_char());
                end else if (fold_en && p >= CH_UP_A && p <= CH_UP_Z
                             && $urandom_range(0, 1)) begin
                    nm.push_back(p + CASE_OFS);
                end else if (fold_en && p >= CH_UP_A + CASE_OFS && p <= CH_UP_Z + CASE_OFS
                             && $urandom_range(0, 1)) begin
                    nm.push_back(p - CASE_OFS);
                end else begin
                    nm.push_back(p);
                end
            end
            if (nm.size() != 0 && $urandom_range(0, 3) == 0) begin
                case ($urandom_range(0, 2))
                    0:       nm[$urandom_range(0, nm.size() - 1)] = pick_name_char();
                    1:       void'(nm.pop_back());
                    default: nm.push_back(pick_name_char());
                endcase
            end
        end else begin
            repeat ($urandom_range(1, 6)) nm.push_back(BYTE_W'($urandom_range(0, 255)));
        end
        if (nm.size() == 0) nm.push_back(pick_name_char());
        foreach (nm[j]) queue_char(nm[j], complete && (j == nm.size() - 1));
    endfunction

    task automatic write_reg(input t_cfg_idx idx, input logic [DATA_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            CFG_WORD0, CFG_WORD1, CFG_WORD2, CFG_WORD3: pat_words[idx] = val;
            CFG_LEN:  pat_len_reg = val[LEN_W-1:0];
            CFG_FOLD: fold_en = val[0];
            default:  ;
        endcase
        cfg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // trailing non-final characters may still sit in the block after the last flag
    task automatic wait_idle();
        while (pending_chars.size() != 0 || match_expected_q.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    always @(negedge clk) begin : sender
        int g;
        if (!rst_n) begin
            push     <= 1'b0;
            send_gap <= 0;
        end else begin
            g = send_gap;
            if (in_beat) begin
                if (send_burst > 0) begin
                    send_burst <= send_burst - 1;
                    g = 0;
                end else begin
                    g = pick_gap();
                    if ($urandom_range(0, 49) == 0) send_burst <= 40;
                end
            end
            if (g > 0) begin
                push     <= 1'b0;
                send_gap <= g - 1;
            end else begin
                send_gap <= 0;
                if (pending_chars.size() != 0) begin
                    push      <= 1'b1;
                    name_char <= pending_chars[0].ch;
                    last_char <= pending_chars[0].last;
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    always @(negedge clk) begin : receiver
        int g;
        if (!rst_n) begin
            pop      <= 1'b0;
            recv_gap <= 0;
        end else begin
            g = recv_gap;
            if (out_beat) begin
                if (recv_burst > 0) begin
                    recv_burst <= recv_burst - 1;
                    g = 0;
                end else begin
                    g = pick_gap();
                    if ($urandom_range(0, 49) == 0) recv_burst <= 40;
                end
            end
            // one long hold-off with plenty of traffic queued, to back up the input
            if (!hold_done && results_seen >= DIRECTED_NAMES && pending_chars.size() > 120)
            begin
                hold_done <= 1'b1;
                g = LONG_HOLD;
            end
            if (g > 0) begin
                pop      <= 1'b0;
                recv_gap <= g - 1;
            end else begin
                pop      <= 1'b1;
                recv_gap <= 0;
            end
        end
    end

    always @(posedge clk) begin : monitor
        logic exp_match;
        if (!rst_n) begin
            in_beat     <= 1'b0;
            out_beat    <= 1'b0;
            idle_cycles <= 0;
        end else begin
            in_beat  <= push && !full;
            out_beat <= pop && !empty;
            if (pop && !empty) begin
                if (match_expected_q.size() == 0) begin
                    $error("matched: no result expected, actual %0b", matched);
                    error_count++;
                end else begin
                    exp_match = match_expected_q.pop_front();
                    if (matched !== exp_match) begin
                        $error("matched: expected %0b, actual %0b", exp_match, matched);
                        error_count++;
                    end
                    results_seen++;
                    if (matched === 1'b1) matches_seen++;
                end
            end
            if (push && !full) begin
                consume_char(name_char, last_char);
                void'(pending_chars.pop_front());
                chars_seen++;
            end
            if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin : watchdog
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
        $display("tb: failure");
        $finish;
    end

    initial begin : stimulus
        logic [BYTE_W-1:0] pb [REG_BYTES];
        logic [DATA_W-1:0] wv;
        int                plen, eff, r, target, start;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        wait_idle();

        // reset pattern is empty: nothing matches
        queue_char(8'h00, 1'b1);
        wait_idle();
        settings_used++;

        // literal with zero byte, '?', trailing stars, folding on
        write_reg(CFG_WORD0, {8'h7E, CH_STAR, 8'h00, CH_STAR, CH_STAR, CH_QMARK,
                              8'h00, CH_UP_A});
        write_reg(CFG_LEN, 64'd5);
        write_reg(CFG_FOLD, 64'd1);
        settings_used++;
        @(posedge clk);
        queue_char("a", 1'b0);
        queue_char(8'h00, 1'b0);
        queue_char(8'hFF, 1'b1);
        queue_char("Z", 1'b1);
        queue_char("A", 1'b0);
        wait_idle();

        // folding switched off in the middle of a name
        write_reg(CFG_FOLD, 64'd0);
        settings_used++;
        @(posedge clk);
        queue_char(8'h00, 1'b0);
        queue_char(8'h80, 1'b1);
        wait_idle();

        // over-long length saturates at the register capacity
        write_reg(CFG_WORD0, {8{CH_QMARK}});
        write_reg(CFG_WORD1, {8{CH_STAR}});
        write_reg(CFG_WORD2, {8{CH_STAR}});
        write_reg(CFG_WORD3, {8{CH_STAR}});
        write_reg(CFG_LEN, 64'd63);
        settings_used++;
        @(posedge clk);
        repeat (7) queue_char(8'hFF, 1'b0);
        queue_char(8'h00, 1'b1);
        queue_char("b", 1'b0);
        queue_char("c", 1'b1);
        wait_idle();

        start = queued_chars;
        while (queued_chars < start + RANDOM_CHARS) begin
            r = $urandom_range(0, 9);
            if (r == 0) plen = 0;
            else if (r == 1) plen = $urandom_range(33, 63);
            else if (r == 2) plen = 32;
            else plen = $urandom_range(1, 10);
            eff = (plen > PAT_MAX) ? PAT_MAX : plen;
            for (int k = 0; k < REG_BYTES; k++) begin
                r = $urandom_range(0, 9);
                if (k >= eff) pb[k] = BYTE_W'($urandom_range(0, 255));
                else if (r < 3) pb[k] = CH_STAR;
                else if (r == 3) pb[k] = CH_QMARK;
                else pb[k] = pick_name_char();
            end
            for (int w = 0; w < WORD_COUNT; w++) begin
                for (int k = 0; k < 8; k++) wv[k * 8 +: 8] = pb[w * 8 + k];
                write_reg(t_cfg_idx'(w), wv);
            end
            wv = {$urandom, $urandom};
            wv[LEN_W-1:0] = LEN_W'(plen);
            write_reg(CFG_LEN, wv);
            write_reg(CFG_FOLD, {$urandom, $urandom});
            settings_used++;
            @(posedge clk);
            target = queued_chars + $urandom_range(150, 250);
            while (queued_chars < target) add_name($urandom_range(0, 4) != 0, 1'b1);
            if ($urandom_range(0, 2) == 0) add_name(1'b1, 1'b0);
            wait_idle();
        end

        $display("summary: %0d characters sent, %0d names checked, %0d of them matching",
                 chars_seen, results_seen, matches_seen);
        $display("summary: %0d register writes across %0d pattern settings",
                 cfg_writes, settings_used);
        if (error_count == 0 && match_expected_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ glob_wildcard_matcher_top.f @@
rtl/gwm_pkg.sv
rtl/gwm_front.sv
rtl/gwm_queue.sv
rtl/gwm_back.sv
rtl/glob_wildcard_matcher_top.sv
test/tb_glob_wildcard_matcher_top.sv
